[sv/mamt_pkg.sv]
`timescale 1ns / 1ps

package mamt_pkg;

    localparam int DIM_W      = 4;
    localparam int IDX_W      = 3;
    localparam int OUT_W      = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int SUM_W      = 7;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    typedef enum logic [2:0] {
        OP_LOAD_A = 3'd0,
        OP_LOAD_B = 3'd1,
        OP_ADD    = 3'd2,
        OP_MUL    = 3'd3,
        OP_TRN    = 3'd4
    } op_t;

    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] cols_a;
        logic [DIM_W-1:0] rows_b;
        logic [DIM_W-1:0] cols_b;
    } dims_t;

    typedef struct packed {
        logic             load_a;
        logic             load_b;
        logic             clr_cnt;
        logic             clr_acc;
        logic             issue;
        logic             first;
        op_t              op;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } mat_cmd_t;

    typedef struct packed {
        logic busy;
    } mat_sts_t;

    function automatic logic dim_ok(logic [DIM_W-1:0] d, logic [DIM_W-1:0] max_d);
        return (d != '0) && (d <= max_d);
    endfunction

endpackage

[sv/mamt_datapath.sv]
`timescale 1ns / 1ps

module mamt_datapath #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mamt_pkg::dims_t                      dims,
    input  mamt_pkg::mat_cmd_t                   cmd,
    input  logic signed [31:0]                   element,
    output mamt_pkg::mat_sts_t                   sts,
    output logic signed [mamt_pkg::OUT_W-1:0]    value
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [mamt_pkg::DIM_W-1:0] MAX_D = mamt_pkg::DIM_W'(MAX_DIM);

    logic [DATA_WIDTH-1:0] mem_a [DEPTH];
    logic [DATA_WIDTH-1:0] mem_b [DEPTH];

    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;

    logic [DATA_WIDTH-1:0]        rd_a_reg, rd_b_reg;
    logic                         v1_reg, first1_reg;
    mamt_pkg::op_t                op1_reg;
    logic [DATA_WIDTH-1:0]        term_reg, term_next;
    logic                         v2_reg, first2_reg;
    logic signed [DATA_WIDTH-1:0] acc_reg;

    logic       a_ok, b_ok, a_can, b_can;
    logic [7:0] lim_a, lim_b;

    logic [mamt_pkg::IDX_W-1:0] ar, ac, br;
    logic [mamt_pkg::SUM_W-1:0] a_sum, b_sum;
    logic [ADDR_W-1:0]          a_addr, b_addr;

    // load admission
    always_comb begin
        a_ok  = mamt_pkg::dim_ok(dims.rows_a, MAX_D) && mamt_pkg::dim_ok(dims.cols_a, MAX_D);
        b_ok  = mamt_pkg::dim_ok(dims.rows_b, MAX_D) && mamt_pkg::dim_ok(dims.cols_b, MAX_D);
        lim_a = 8'(dims.rows_a) * 8'(dims.cols_a);
        lim_b = 8'(dims.rows_b) * 8'(dims.cols_b);
        a_can = cmd.load_a && a_ok && (8'(cnt_a_reg) < lim_a);
        b_can = cmd.load_b && b_ok && (8'(cnt_b_reg) < lim_b);

        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        if (cmd.clr_cnt) begin
            cnt_a_next = '0;
            cnt_b_next = '0;
        end else begin
            if (a_can) begin
                cnt_a_next = cnt_a_reg + 1'b1;
            end
            if (b_can) begin
                cnt_b_next = cnt_b_reg + 1'b1;
            end
        end
    end

    // read address generation
    always_comb begin
        ar = (cmd.op == mamt_pkg::OP_TRN) ? cmd.j : cmd.i;
        unique case (cmd.op)
            mamt_pkg::OP_MUL: ac = cmd.k;
            mamt_pkg::OP_TRN: ac = cmd.i;
            default:          ac = cmd.j;
        endcase
        br     = (cmd.op == mamt_pkg::OP_MUL) ? cmd.k : cmd.i;
        a_sum  = mamt_pkg::SUM_W'(ar) * mamt_pkg::SUM_W'(dims.cols_a)
               + mamt_pkg::SUM_W'(ac);
        b_sum  = mamt_pkg::SUM_W'(br) * mamt_pkg::SUM_W'(dims.cols_b)
               + mamt_pkg::SUM_W'(cmd.j);
        a_addr = a_sum[ADDR_W-1:0];
        b_addr = b_sum[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (a_can) begin
            mem_a[cnt_a_reg[ADDR_W-1:0]] <= element[DATA_WIDTH-1:0];
        end
        rd_a_reg <= mem_a[a_addr];
    end

    always_ff @(posedge aclk) begin
        if (b_can) begin
            mem_b[cnt_b_reg[ADDR_W-1:0]] <= element[DATA_WIDTH-1:0];
        end
        rd_b_reg <= mem_b[b_addr];
    end

    always_comb begin
        unique case (op1_reg)
            mamt_pkg::OP_ADD: term_next = rd_a_reg + rd_b_reg;
            mamt_pkg::OP_MUL: term_next = rd_a_reg * rd_b_reg;
            default:          term_next = rd_a_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            v1_reg    <= cmd.issue;
            v2_reg    <= v1_reg;
        end
    end

    // multiply-accumulate pipeline payload
    always_ff @(posedge aclk) begin
        first1_reg <= cmd.first;
        op1_reg    <= cmd.op;
        term_reg   <= term_next;
        first2_reg <= first1_reg;
        if (cmd.clr_acc) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= first2_reg ? signed'(term_reg) : acc_reg + signed'(term_reg);
        end
    end

    assign sts.busy = v1_reg || v2_reg;
    assign value    = mamt_pkg::OUT_W'(acc_reg);

endmodule

[sv/mamt_ctrl.sv]
`timescale 1ns / 1ps

module mamt_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mamt_pkg::dims_t                  dims,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_opcode,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mamt_pkg::IDX_W-1:0]       m_row_index,
    output logic [mamt_pkg::IDX_W-1:0]       m_col_index,
    output logic                             m_last,
    output logic                             m_dim_error,
    output mamt_pkg::mat_cmd_t               cmd,
    input  mamt_pkg::mat_sts_t               sts
);

    localparam logic [mamt_pkg::DIM_W-1:0] MAX_D = mamt_pkg::DIM_W'(MAX_DIM);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t                      state_reg;
    logic [mamt_pkg::IDX_W-1:0]  i_reg, j_reg, k_reg;
    logic [mamt_pkg::DIM_W-1:0]  nr_reg, nc_reg, klen_reg;
    mamt_pkg::op_t               op_reg;
    logic                        m_valid_reg, last_reg, err_reg;

    logic                        accept, is_op, a_ok, b_ok, op_err;
    logic [mamt_pkg::DIM_W-1:0]  nr_new, nc_new, klen_new;
    logic                        k_end, i_end, j_end;

    assign accept = s_valid && s_ready;
    assign is_op  = (s_opcode == mamt_pkg::OP_ADD) || (s_opcode == mamt_pkg::OP_MUL)
                 || (s_opcode == mamt_pkg::OP_TRN);

    always_comb begin
        a_ok = mamt_pkg::dim_ok(dims.rows_a, MAX_D) && mamt_pkg::dim_ok(dims.cols_a, MAX_D);
        b_ok = mamt_pkg::dim_ok(dims.rows_b, MAX_D) && mamt_pkg::dim_ok(dims.cols_b, MAX_D);
        priority if (s_opcode == mamt_pkg::OP_ADD) begin
            op_err   = !a_ok || !b_ok || (dims.rows_a != dims.rows_b)
                    || (dims.cols_a != dims.cols_b);
            nr_new   = dims.rows_a;
            nc_new   = dims.cols_a;
            klen_new = 4'd1;
        end else if (s_opcode == mamt_pkg::OP_MUL) begin
            op_err   = !a_ok || !b_ok || (dims.cols_a != dims.rows_b);
            nr_new   = dims.rows_a;
            nc_new   = dims.cols_b;
            klen_new = dims.cols_a;
        end else begin
            op_err   = !a_ok;
            nr_new   = dims.cols_a;
            nc_new   = dims.rows_a;
            klen_new = 4'd1;
        end
    end

    assign k_end = (mamt_pkg::DIM_W'(k_reg) + 1'b1) == klen_reg;
    assign i_end = (mamt_pkg::DIM_W'(i_reg) + 1'b1) == nr_reg;
    assign j_end = (mamt_pkg::DIM_W'(j_reg) + 1'b1) == nc_reg;

    always_comb begin
        cmd         = '0;
        cmd.op      = op_reg;
        cmd.i       = i_reg;
        cmd.j       = j_reg;
        cmd.k       = k_reg;
        cmd.load_a  = accept && (s_opcode == mamt_pkg::OP_LOAD_A);
        cmd.load_b  = accept && (s_opcode == mamt_pkg::OP_LOAD_B);
        cmd.clr_cnt = accept && is_op;
        cmd.clr_acc = accept && is_op && op_err;
        cmd.issue   = (state_reg == ST_RUN);
        cmd.first   = (k_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            nr_reg      <= '0;
            nc_reg      <= '0;
            klen_reg    <= '0;
            op_reg      <= mamt_pkg::OP_ADD;
            m_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
            err_reg     <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && is_op) begin
                        i_reg    <= '0;
                        j_reg    <= '0;
                        k_reg    <= '0;
                        nr_reg   <= nr_new;
                        nc_reg   <= nc_new;
                        klen_reg <= klen_new;
                        op_reg   <= mamt_pkg::op_t'(s_opcode);
                        if (op_err) begin
                            err_reg     <= 1'b1;
                            last_reg    <= 1'b1;
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_OUT;
                        end else begin
                            err_reg   <= 1'b0;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (k_end) begin
                        k_reg     <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!sts.busy) begin
                        last_reg    <= i_end && j_end;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            if (j_end) begin
                                j_reg <= '0;
                                i_reg <= i_reg + 1'b1;
                            end else begin
                                j_reg <= j_reg + 1'b1;
                            end
                            state_reg <= ST_RUN;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_row_index = i_reg;
    assign m_col_index = j_reg;
    assign m_last      = last_reg;
    assign m_dim_error = err_reg;

endmodule

[sv/matrix_add_multiply_transpose.sv]
`timescale 1ns / 1ps

// integer matrix unit: holds matrices a and b, returns a+b, a*b or transpose of a
// input channel (s_*): opcode plus element; load beats (opcodes 0 and 1) write the
//   next row-major element of a or b and produce no output beat
// output channel (m_*): one beat per result element, row-major, m_last on the final
//   element; a bad or mismatched dimension gives a single beat with m_dim_error,
//   m_last set and m_value zero
// an operation beat is taken only when the previous result run has fully drained;
//   s_ready is low from an operation beat until the last output beat is taken
// each output element takes K reads through the single read port of each store
//   (K = cols_a for multiply, 1 otherwise), then the two-stage multiply-accumulate
//   pipeline drains into the output register
// a dimension error is presented in the cycle after the operation beat
// m_ready low simply holds the output register; nothing advances until it is taken
// dimensions are set over the apb port (rows_a, cols_a, rows_b, cols_b at 0x0..0xc)
//   and must only be written while no operation is in flight
// reset sets all dimensions to 8 and clears both load counters; store contents
//   are undefined until loaded

module matrix_add_multiply_transpose #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mamt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mamt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mamt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_opcode,
    input  logic signed [31:0]                  s_element,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_value,
    output logic [2:0]                          m_row_index,
    output logic [2:0]                          m_col_index,
    output logic                                m_last,
    output logic                                m_dim_error
);

    mamt_pkg::dims_t     dims_reg;
    mamt_pkg::mat_cmd_t  cmd;
    mamt_pkg::mat_sts_t  sts;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg.rows_a <= mamt_pkg::DIM_RESET;
            dims_reg.cols_a <= mamt_pkg::DIM_RESET;
            dims_reg.rows_b <= mamt_pkg::DIM_RESET;
            dims_reg.cols_b <= mamt_pkg::DIM_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                mamt_pkg::REG_ROWS_A: dims_reg.rows_a <= pwdata[mamt_pkg::DIM_W-1:0];
                mamt_pkg::REG_COLS_A: dims_reg.cols_a <= pwdata[mamt_pkg::DIM_W-1:0];
                mamt_pkg::REG_ROWS_B: dims_reg.rows_b <= pwdata[mamt_pkg::DIM_W-1:0];
                mamt_pkg::REG_COLS_B: dims_reg.cols_b <= pwdata[mamt_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            mamt_pkg::REG_ROWS_A: prdata = mamt_pkg::APB_DATA_W'(dims_reg.rows_a);
            mamt_pkg::REG_COLS_A: prdata = mamt_pkg::APB_DATA_W'(dims_reg.cols_a);
            mamt_pkg::REG_ROWS_B: prdata = mamt_pkg::APB_DATA_W'(dims_reg.rows_b);
            mamt_pkg::REG_COLS_B: prdata = mamt_pkg::APB_DATA_W'(dims_reg.cols_b);
            default:              prdata = '0;
        endcase
    end

    mamt_ctrl #(
        .MAX_DIM     (MAX_DIM)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dims        (dims_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_index (m_row_index),
        .m_col_index (m_col_index),
        .m_last      (m_last),
        .m_dim_error (m_dim_error),
        .cmd         (cmd),
        .sts         (sts)
    );

    mamt_datapath #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dims       (dims_reg),
        .cmd        (cmd),
        .element    (s_element),
        .sts        (sts),
        .value      (m_value)
    );

    a_err_beat_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dim_error |-> m_last && (m_value == '0)
            && (m_row_index == '0) && (m_col_index == '0))
        else $error("dimension error beat malformed");

    a_no_input_while_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result beat is pending");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> s_ready && !m_valid)
        else $error("block not idle after final result beat");

    a_pipe_quiet_on_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !sts.busy)
        else $error("accumulator still updating while result is presented");

endmodule

[dv/matrix_add_multiply_transpose_tb.sv]
`timescale 1ns / 1ps

module matrix_add_multiply_transpose_tb;

    localparam int MAX_DIM     = 8;
    localparam int STORE_WORDS = MAX_DIM * MAX_DIM;
    localparam int RAND_ITEMS  = 30;
    localparam int QUIET_FROM  = 12;
    localparam int LOAD_CAP    = 6;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 16;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct packed {
        logic [31:0]                value;
        logic [mamt_pkg::IDX_W-1:0] row;
        logic [mamt_pkg::IDX_W-1:0] col;
        logic                       last;
        logic                       err;
    } res_t;

    typedef struct packed {
        logic [mamt_pkg::DIM_W-1:0] ra;
        logic [mamt_pkg::DIM_W-1:0] ca;
        logic [mamt_pkg::DIM_W-1:0] rb;
        logic [mamt_pkg::DIM_W-1:0] cb;
        logic [2:0]                 op;
        logic [31:0]                elem;
        logic                       typed;
        res_t                       want;
    } step_t;

    localparam res_t NO_RES   = '0;
    localparam res_t DIM_FAIL = '{32'd0, 3'd0, 3'd0, 1'b1, 1'b1};
    localparam res_t MIN_ONE  = '{32'h8000_0000, 3'd0, 3'd0, 1'b1, 1'b0};

    localparam int DIR_N = 26;
    localparam step_t DIRECTED [DIR_N] = '{
        '{4'd8, 4'd8, 4'd8, 4'd8, mamt_pkg::OP_MUL,    32'd0,         1'b0, NO_RES},
        '{4'd8, 4'd8, 4'd8, 4'd8, mamt_pkg::OP_ADD,    32'd0,         1'b0, NO_RES},
        '{4'd8, 4'd8, 4'd8, 4'd8, mamt_pkg::OP_TRN,    32'hffff_ffff, 1'b0, NO_RES},
        '{4'd1, 4'd1, 4'd1, 4'd1, mamt_pkg::OP_LOAD_A, 32'h7fff_ffff, 1'b0, NO_RES},
        '{4'd1, 4'd1, 4'd1, 4'd1, mamt_pkg::OP_LOAD_B, 32'd1,         1'b0, NO_RES},
        '{4'd1, 4'd1, 4'd1, 4'd1, mamt_pkg::OP_ADD,    32'd0,         1'b1, MIN_ONE},
        '{4'd1, 4'd1, 4'd1, 4'd1, mamt_pkg::OP_LOAD_A, 32'h8000_0000, 1'b0, NO_RES},
        '{4'd1, 4'd1, 4'd1, 4'd1, mamt_pkg::OP_LOAD_A, 32'd5,         1'b0, NO_RES},
        '{4'd1, 4'd1, 4'd1, 4'd1, mamt_pkg::OP_LOAD_B, 32'hffff_ffff, 1'b0, NO_RES},
        '{4'd1, 4'd1, 4'd1, 4'd1, mamt_pkg::OP_MUL,    32'd0,         1'b1, MIN_ONE},
        '{4'd1, 4'd1, 4'd1, 4'd1, mamt_pkg::OP_TRN,    32'd0,         1'b1, MIN_ONE},
        '{4'd2, 4'd3, 4'd2, 4'd3, mamt_pkg::OP_MUL,    32'd0,         1'b1, DIM_FAIL},
        '{4'd2, 4'd3, 4'd2, 4'd3, mamt_pkg::OP_ADD,    32'd0,         1'b0, NO_RES},
        '{4'd2, 4'd3, 4'd2, 4'd3, mamt_pkg::OP_TRN,    32'd0,         1'b0, NO_RES},
        '{4'd2, 4'd3, 4'd3, 4'd2, mamt_pkg::OP_ADD,    32'd0,         1'b1, DIM_FAIL},
        '{4'd2, 4'd3, 4'd3, 4'd2, mamt_pkg::OP_MUL,    32'd0,         1'b0, NO_RES},
        '{4'd0, 4'd3, 4'd3, 4'd2, mamt_pkg::OP_TRN,    32'd0,         1'b1, DIM_FAIL},
        '{4'd0, 4'd3, 4'd3, 4'd2, mamt_pkg::OP_LOAD_A, 32'hffff_ffff, 1'b0, NO_RES},
        '{4'd0, 4'd3, 4'd3, 4'd2, mamt_pkg::OP_MUL,    32'd0,         1'b1, DIM_FAIL},
        '{4'd9, 4'd15, 4'd15, 4'd9, mamt_pkg::OP_ADD,  32'd0,         1'b1, DIM_FAIL},
        '{4'd9, 4'd15, 4'd15, 4'd9, OP_SPARE5,         32'd7,         1'b0, NO_RES},
        '{4'd9, 4'd15, 4'd15, 4'd9, OP_SPARE6,         32'd7,         1'b0, NO_RES},
        '{4'd9, 4'd15, 4'd15, 4'd9, OP_SPARE7,         32'd7,         1'b0, NO_RES},
        '{4'd8, 4'd1, 4'd1, 4'd8, mamt_pkg::OP_MUL,    32'd0,         1'b0, NO_RES},
        '{4'd8, 4'd1, 4'd1, 4'd8, mamt_pkg::OP_LOAD_A, 32'd0,         1'b0, NO_RES},
        '{4'd1, 4'd8, 4'd8, 4'd1, mamt_pkg::OP_MUL,    32'd0,         1'b0, NO_RES}
    };

    logic                            aclk;
    logic                            aresetn;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mamt_pkg::APB_ADDR_W-1:0] paddr;
    logic [mamt_pkg::APB_DATA_W-1:0] pwdata;
    logic [mamt_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_valid;
    logic                            s_ready;
    logic [2:0]                      s_opcode;
    logic signed [31:0]              s_element;
    logic                            m_valid;
    logic                            m_ready;
    logic signed [31:0]              m_value;
    logic [2:0]                      m_row_index;
    logic [2:0]                      m_col_index;
    logic                            m_last;
    logic                            m_dim_error;

    // shadow of the block
    logic [mamt_pkg::DIM_W-1:0] ra, ca, rb, cb;
    logic [31:0]                mat_a [STORE_WORDS];
    logic [31:0]                mat_b [STORE_WORDS];
    logic [6:0]                 cnt_a, cnt_b;

    res_t calc_q [$];
    res_t result_q [$];
    res_t head;

    int  errors;
    int  taken;
    int  results_checked;
    int  ops_run;
    int  dim_fails;
    int  dim_settings;
    int  cycles;
    int  hold_left;
    bit  quiet;
    bit  squeeze_now;
    bit  squeeze_done;

    matrix_add_multiply_transpose u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_element   (s_element),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_row_index (m_row_index),
        .m_col_index (m_col_index),
        .m_last      (m_last),
        .m_dim_error (m_dim_error)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic bit dim_good(input logic [mamt_pkg::DIM_W-1:0] d);
        return (d >= 1) && (int'(d) <= MAX_DIM);
    endfunction

    // updates the shadow state for one beat and leaves its results in calc_q;
    // returns 0 when the beat changes nothing
    function automatic bit model_beat(input logic [2:0] op, input logic [31:0] elem);
        bit          a_ok;
        bit          b_ok;
        bit          bad;
        int          nr;
        int          nc;
        logic [31:0] acc;
        res_t        r;
        a_ok = dim_good(ra) && dim_good(ca);
        b_ok = dim_good(rb) && dim_good(cb);
        calc_q.delete();
        if (op == mamt_pkg::OP_LOAD_A) begin
            if (!a_ok || int'(cnt_a) >= int'(ra) * int'(ca)) return 1'b0;
            mat_a[cnt_a[5:0]] = elem;
            cnt_a = cnt_a + 7'd1;
            return 1'b1;
        end
        if (op == mamt_pkg::OP_LOAD_B) begin
            if (!b_ok || int'(cnt_b) >= int'(rb) * int'(cb)) return 1'b0;
            mat_b[cnt_b[5:0]] = elem;
            cnt_b = cnt_b + 7'd1;
            return 1'b1;
        end
        if (op > mamt_pkg::OP_TRN) return 1'b0;
        cnt_a = '0;
        cnt_b = '0;
        ops_run++;
        case (op)
            mamt_pkg::OP_ADD: begin
                bad = !a_ok || !b_ok || ra != rb || ca != cb;
                nr  = ra;
                nc  = ca;
            end
            mamt_pkg::OP_MUL: begin
                bad = !a_ok || !b_ok || ca != rb;
                nr  = ra;
                nc  = cb;
            end
            default: begin
                bad = !a_ok;
                nr  = ca;
                nc  = ra;
            end
        endcase
        if (bad) begin
            dim_fails++;
            calc_q.push_back(DIM_FAIL);
            return 1'b1;
        end
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                if (op == mamt_pkg::OP_ADD) begin
                    acc = mat_a[i * int'(ca) + j] + mat_b[i * int'(cb) + j];
                end else if (op == mamt_pkg::OP_MUL) begin
                    acc = '0;
                    for (int k = 0; k < int'(ca); k++)
                        acc = acc + mat_a[i * int'(ca) + k] * mat_b[k * int'(cb) + j];
                end else begin
                    acc = mat_a[j * int'(ca) + i];
                end
                r.value = acc;
                r.row   = mamt_pkg::IDX_W'(i);
                r.col   = mamt_pkg::IDX_W'(j);
                r.last  = (i == nr - 1) && (j == nc - 1);
                r.err   = 1'b0;
                calc_q.push_back(r);
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [mamt_pkg::DIM_W-1:0] pick_dim();
        return ($urandom_range(0, 7) == 0) ? mamt_pkg::DIM_W'(MAX_DIM)
                                           : mamt_pkg::DIM_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [mamt_pkg::DIM_W-1:0] bad_dim();
        return ($urandom_range(0, 1) == 0) ? '0
                                           : mamt_pkg::DIM_W'($urandom_range(MAX_DIM + 1, 15));
    endfunction

    function automatic logic [2:0] pick_op(input int pat);
        logic [2:0] any_op;
        any_op = 3'($urandom_range(int'(mamt_pkg::OP_ADD), int'(mamt_pkg::OP_TRN)));
        if (pat >= 8 || $urandom_range(0, 2) == 0) return any_op;
        return (pat < 4) ? mamt_pkg::OP_ADD : mamt_pkg::OP_MUL;
    endfunction

    task automatic drive_item(input logic [2:0] op, input logic [31:0] elem,
                              input logic typed, input res_t want);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_element <= elem;
        do @(posedge aclk); while (!s_ready);
        if (model_beat(op, elem)) begin
            taken++;
            if (typed)
                result_q.push_back(want);
            else
                foreach (calc_q[q]) result_q.push_back(calc_q[q]);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx, input logic [31:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("prdata reg %0d: expected %0h got %0h", idx, want, prdata);
            errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_dims(input logic [31:0] w_ra, input logic [31:0] w_ca,
                            input logic [31:0] w_rb, input logic [31:0] w_cb);
        apb_write(mamt_pkg::REG_ROWS_A, w_ra);
        apb_write(mamt_pkg::REG_COLS_A, w_ca);
        apb_write(mamt_pkg::REG_ROWS_B, w_rb);
        apb_write(mamt_pkg::REG_COLS_B, w_cb);
        ra = w_ra[mamt_pkg::DIM_W-1:0];
        ca = w_ca[mamt_pkg::DIM_W-1:0];
        rb = w_rb[mamt_pkg::DIM_W-1:0];
        cb = w_cb[mamt_pkg::DIM_W-1:0];
        apb_read(mamt_pkg::REG_ROWS_A, 32'(ra));
        apb_read(mamt_pkg::REG_COLS_A, 32'(ca));
        apb_read(mamt_pkg::REG_ROWS_B, 32'(rb));
        apb_read(mamt_pkg::REG_COLS_B, 32'(cb));
        dim_settings++;
    endtask

    // block idle: nothing offered, every result back, pipeline drained
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic logic [31:0] with_junk(input logic [mamt_pkg::DIM_W-1:0] d);
        logic [31:0] w;
        w = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        w[mamt_pkg::DIM_W-1:0] = d;
        return w;
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (result_q.size() == 0) begin
                $error("unexpected result beat: value %0h row %0d col %0d",
                       m_value, m_row_index, m_col_index);
                errors++;
            end else begin
                head = result_q.pop_front();
                if (m_value !== head.value) begin
                    $error("value: expected %0h got %0h", head.value, m_value);
                    errors++;
                end
                if (m_row_index !== head.row) begin
                    $error("row_index: expected %0d got %0d", head.row, m_row_index);
                    errors++;
                end
                if (m_col_index !== head.col) begin
                    $error("col_index: expected %0d got %0d", head.col, m_col_index);
                    errors++;
                end
                if (m_last !== head.last) begin
                    $error("last: expected %0b got %0b", head.last, m_last);
                    errors++;
                end
                if (m_dim_error !== head.err) begin
                    $error("dim_error: expected %0b got %0b", head.err, m_dim_error);
                    errors++;
                end
            end
        end
    end

    // result side backpressure
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (squeeze_now && !squeeze_done) begin
                squeeze_done = 1'b1;
                hold_left    = LONG_HOLD;
                m_ready     <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 2);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int                         base;
        int                         pat;
        int                         na;
        int                         nb;
        int                         nops;
        logic [mamt_pkg::DIM_W-1:0] nd [4];
        step_t                      st;

        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_opcode  = '0;
        s_element = '0;
        ra        = mamt_pkg::DIM_RESET;
        ca        = mamt_pkg::DIM_RESET;
        rb        = mamt_pkg::DIM_RESET;
        cb        = mamt_pkg::DIM_RESET;
        cnt_a     = '0;
        cnt_b     = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        apb_read(mamt_pkg::REG_ROWS_A, 32'(mamt_pkg::DIM_RESET));
        apb_read(mamt_pkg::REG_COLS_A, 32'(mamt_pkg::DIM_RESET));
        apb_read(mamt_pkg::REG_ROWS_B, 32'(mamt_pkg::DIM_RESET));
        apb_read(mamt_pkg::REG_COLS_B, 32'(mamt_pkg::DIM_RESET));

        // fill both stores completely so no later read hits an unwritten entry
        for (int k = 0; k < STORE_WORDS; k++)
            drive_item(mamt_pkg::OP_LOAD_A, rand_elem(), 1'b0, NO_RES);
        for (int k = 0; k < STORE_WORDS; k++)
            drive_item(mamt_pkg::OP_LOAD_B, rand_elem(), 1'b0, NO_RES);

        for (int n = 0; n < DIR_N; n++) begin
            st = DIRECTED[n];
            if ({st.ra, st.ca, st.rb, st.cb} != {ra, ca, rb, cb}) begin
                settle();
                set_dims(32'(st.ra), 32'(st.ca), 32'(st.rb), 32'(st.cb));
            end
            drive_item(st.op, st.elem, st.typed, st.want);
            // long receiver stall while the next operations wait at the input
            if (n == 0) squeeze_now = 1'b1;
        end

        base = taken;
        while (taken - base < RAND_ITEMS) begin
            pat = $urandom_range(0, 9);
            foreach (nd[d]) nd[d] = pick_dim();
            if (pat < 4) begin
                nd[2] = nd[0];
                nd[3] = nd[1];
            end else if (pat < 8) begin
                nd[2] = nd[1];
            end else if (pat == 9) begin
                nd[$urandom_range(0, 3)] = bad_dim();
            end
            settle();
            set_dims(with_junk(nd[0]), with_junk(nd[1]), with_junk(nd[2]), with_junk(nd[3]));
            if (taken - base >= QUIET_FROM) quiet = 1'b1;

            if ($urandom_range(0, 4) != 0) begin
                na = (dim_good(ra) && dim_good(ca)) ? int'(ra) * int'(ca) : 2;
                nb = (dim_good(rb) && dim_good(cb)) ? int'(rb) * int'(cb) : 2;
                if (na > LOAD_CAP) na = $urandom_range(1, LOAD_CAP);
                if (nb > LOAD_CAP) nb = $urandom_range(1, LOAD_CAP);
                for (int k = 0; k < na; k++)
                    drive_item(mamt_pkg::OP_LOAD_A, rand_elem(), 1'b0, NO_RES);
                for (int k = 0; k < nb; k++)
                    drive_item(mamt_pkg::OP_LOAD_B, rand_elem(), 1'b0, NO_RES);
                // one more load, ignored when the matrix is already full
                if ($urandom_range(0, 3) == 0)
                    drive_item(($urandom_range(0, 1) == 0) ? mamt_pkg::OP_LOAD_A
                                                           : mamt_pkg::OP_LOAD_B,
                               rand_elem(), 1'b0, NO_RES);
                nops = $urandom_range(1, 3);
                for (int k = 0; k < nops; k++) begin
                    drive_item(pick_op(pat), $urandom, 1'b0, NO_RES);
                end
            end else begin
                repeat ($urandom_range(3, 8)) drive_item(3'($urandom), rand_elem(), 1'b0, NO_RES);
            end
        end

        settle();
        $display("summary: %0d input beats took effect, %0d result beats checked",
                 taken, results_checked);
        $display("summary: %0d operations (%0d with dimension error), %0d dimension settings",
                 ops_run, dim_fails, dim_settings);
        if (errors == 0 && result_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[matrix_add_multiply_transpose.f]
sv/mamt_pkg.sv
sv/mamt_datapath.sv
sv/mamt_ctrl.sv
sv/matrix_add_multiply_transpose.sv
dv/matrix_add_multiply_transpose_tb.sv
